// ----- sv/salru_pkg.sv -----
// Shared types, defaults and geometry helpers for the LRU tag store.
`default_nettype none

package salru_pkg;

   // Default geometry
   localparam int CACHE_BYTES_DEF = 256;
   localparam int LINE_BYTES_DEF  = 32;
   localparam int WAYS_DEF        = 1;

   // Width of an address and of the miss counter
   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 32;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic read;
      logic update;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic rsp_busy;
   } dp_status_type;

   // Floor of log2; zero for values of 0 and 1 (elaboration only)
   function automatic int floor_log2(input int value);
      int v;
      int n;
      v = value;
      n = 0;
      while (v > 1) begin
         v = v >> 1;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- sv/salru_ctrl.sv -----
// Controller state machine that sequences clearing, lookup and update.
`default_nettype none

module salru_ctrl
   import salru_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the output register is free
            if (!status.rsp_busy) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Commands never overlap
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.load, cmd.read, cmd.update}))
      else $error("controller issued overlapping commands");

   // A load always leads into a memory read
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.read)
      else $error("load not followed by read");

   // A read always leads into the update state
   assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> state_ff == ST_UPDATE)
      else $error("read not followed by update state");

endmodule

`default_nettype wire

// ----- sv/salru_dpath.sv -----
// Datapath: tag and LRU memories, way compare, replacement and miss counter.
`default_nettype none

module salru_dpath
   import salru_pkg::*;
#(
   parameter int CACHE_BYTES = CACHE_BYTES_DEF,
   parameter int LINE_BYTES  = LINE_BYTES_DEF,
   parameter int WAYS        = WAYS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status,
   input  wire logic [ADDR_W-1:0]  req_tdata,
   input  wire logic               req_tuser,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [COUNT_W-1:0]      rsp_tdata,
   output logic                    rsp_tuser
);

   // Geometry
   localparam int OFFSET_BITS = floor_log2(LINE_BYTES);
   localparam int SETS_RAW    = CACHE_BYTES / WAYS / LINE_BYTES;
   localparam int INDEX_BITS  = floor_log2(SETS_RAW);
   localparam int SETS        = 1 << INDEX_BITS;
   localparam int SET_W       = (INDEX_BITS > 0) ? INDEX_BITS : 1;
   localparam int TAG_W       = ADDR_W - OFFSET_BITS - INDEX_BITS;
   localparam int RANK_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W       = RANK_W;
   localparam int OLD_W       = RANK_W + 1;
   localparam int MW          = 1 + RANK_W;
   localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << INDEX_BITS) - 64'd1);

   // Memories: one row per set
   logic [WAYS*TAG_W-1:0] tag_mem  [SETS];
   logic [WAYS*MW-1:0]    meta_mem [SETS];

   logic [ADDR_W-1:0]     addr_ff;
   logic                  count_ff;
   logic [SET_W-1:0]      clr_idx_ff;
   logic [WAYS*TAG_W-1:0] tag_rd_ff;
   logic [WAYS*MW-1:0]    meta_rd_ff;
   logic [COUNT_W-1:0]    miss_ctr_ff;
   logic [COUNT_W-1:0]    miss_ctr_in;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;

   logic [SET_W-1:0]      set_idx;
   logic [TAG_W-1:0]      acc_tag;

   logic [TAG_W-1:0]      way_tag  [WAYS];
   logic                  way_vld  [WAYS];
   logic [RANK_W-1:0]     way_rank [WAYS];
   logic                  hit_any;
   logic [WAY_W-1:0]      hit_way;
   logic                  free_any;
   logic [WAY_W-1:0]      free_way;
   logic [RANK_W-1:0]     worst;
   logic [WAY_W-1:0]      lru_way;
   logic [WAY_W-1:0]      pick;
   logic [OLD_W-1:0]      old_rank;
   logic [WAYS*TAG_W-1:0] tag_row_new;
   logic [WAYS*MW-1:0]    meta_row_new;

   // Split the held address
   assign set_idx = SET_W'((addr_ff >> OFFSET_BITS) & SET_MASK);
   assign acc_tag = TAG_W'(addr_ff >> (OFFSET_BITS + INDEX_BITS));

   // Capture the accepted transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff  <= req_tdata;
         count_ff <= req_tuser;
      end
   end

   // Clearing pass over the LRU/valid memory
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear) begin
         clr_idx_ff <= clr_idx_ff + SET_W'(1);
      end
   end

   assign status.clear_last = (clr_idx_ff == SET_W'(SETS - 1));
   assign status.rsp_busy   = rsp_valid_ff && !rsp_tready;

   // Memory read ports, registered
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         tag_rd_ff  <= tag_mem[set_idx];
         meta_rd_ff <= meta_mem[set_idx];
      end
   end

   // Memory write ports
   always_ff @(posedge clock) begin
      if (cmd.update && !hit_any) begin
         tag_mem[set_idx] <= tag_row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         meta_mem[clr_idx_ff] <= '0;
      end else if (cmd.update) begin
         meta_mem[set_idx] <= meta_row_new;
      end
   end

   // Way compare, victim choice and recency update
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_tag[w]  = tag_rd_ff[w*TAG_W +: TAG_W];
         way_vld[w]  = meta_rd_ff[w*MW];
         way_rank[w] = meta_rd_ff[w*MW+1 +: RANK_W];
      end

      // lowest matching way and lowest free way
      hit_any  = 1'b0;
      hit_way  = '0;
      free_any = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (way_vld[w] && (way_tag[w] == acc_tag)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!way_vld[w]) begin
            free_any = 1'b1;
            free_way = WAY_W'(w);
         end
      end

      // highest numbered way among those of the oldest rank
      worst   = '0;
      lru_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (way_rank[w] >= worst) begin
            worst   = way_rank[w];
            lru_way = WAY_W'(w);
         end
      end

      if (hit_any) begin
         pick     = hit_way;
         old_rank = OLD_W'(way_rank[hit_way]);
      end else if (free_any) begin
         pick     = free_way;
         old_rank = OLD_W'(WAYS);
      end else begin
         pick     = lru_way;
         old_rank = OLD_W'(worst);
      end

      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == pick) begin
            tag_row_new[w*TAG_W +: TAG_W]   = acc_tag;
            meta_row_new[w*MW]              = 1'b1;
            meta_row_new[w*MW+1 +: RANK_W]  = '0;
         end else begin
            tag_row_new[w*TAG_W +: TAG_W]   = way_tag[w];
            meta_row_new[w*MW]              = way_vld[w];
            if (way_vld[w] && (OLD_W'(way_rank[w]) < old_rank)) begin
               meta_row_new[w*MW+1 +: RANK_W] = way_rank[w] + RANK_W'(1);
            end else begin
               meta_row_new[w*MW+1 +: RANK_W] = way_rank[w];
            end
         end
      end
   end

   // Saturating miss counter
   always_comb begin
      miss_ctr_in = miss_ctr_ff;
      if (cmd.update && !hit_any && count_ff && (miss_ctr_ff != '1)) begin
         miss_ctr_in = miss_ctr_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ctr_ff <= '0;
      end else begin
         miss_ctr_ff <= miss_ctr_in;
      end
   end

   // Output register: set on update, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff <= hit_any;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = miss_ctr_ff;

   // An update always presents a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff)
      else $error("update did not produce a result");

   // An update never overwrites a result still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten before transfer");

   // Hits leave the miss counter alone
   assert property (@(posedge clock) disable iff (reset)
      (cmd.update && hit_any) |=> $stable(miss_ctr_ff))
      else $error("miss counter moved on a hit");

   // The miss counter never decreases
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (miss_ctr_ff >= $past(miss_ctr_ff)))
      else $error("miss counter decreased");

endmodule

`default_nettype wire

// ----- sv/set_associative_lru_tag_store.sv -----
// Top level of the set-associative LRU tag store.
`default_nettype none

// Tag-only set-associative cache with true LRU replacement. Each request
// transfer carries a byte address (req_tdata) and a count flag (req_tuser);
// each response transfer returns the hit flag (rsp_tuser) and the saturating
// miss total after that access (rsp_tdata). An access passes through the
// accept cycle, a registered read of the set's tag and LRU rows, and an
// update cycle that compares all ways in parallel and writes the LRU row,
// and on a miss the tag row, back through the single port of each memory.
// The response sits in an output register, so the next request is accepted
// while it waits; the update stalls only if the previous response has still
// not been taken. After reset it clears the valid/LRU memory, one set per
// cycle over its 2**floor(log2(CACHE_BYTES/WAYS/LINE_BYTES)) sets, 8 with
// the defaults, and accepts no request until it finishes.
module set_associative_lru_tag_store
   import salru_pkg::*;
#(
   parameter int CACHE_BYTES = CACHE_BYTES_DEF,
   parameter int LINE_BYTES  = LINE_BYTES_DEF,
   parameter int WAYS        = WAYS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [ADDR_W-1:0]  req_tdata,   // [31:0] address
   input  wire logic               req_tuser,   // [0] count_miss
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [COUNT_W-1:0]      rsp_tdata,   // [31:0] miss_total
   output logic                    rsp_tuser    // [0] hit
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   salru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Memories and lookup logic
   salru_dpath #(
      .CACHE_BYTES (CACHE_BYTES),
      .LINE_BYTES  (LINE_BYTES),
      .WAYS        (WAYS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
